### hw/rtl/serial_crc_generate_check_unit_assert.svh
// ----------------------------------------------------------------------------
// serial crc unit assertion macros
// shared property forms for the port-level checker
// ----------------------------------------------------------------------------
`ifndef SERIAL_CRC_GENERATE_CHECK_UNIT_ASSERT_SVH
`define SERIAL_CRC_GENERATE_CHECK_UNIT_ASSERT_SVH

// same-cycle implication, quiet during reset
`define SCGC_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("scgc check failed");

// next-cycle implication, quiet during reset
`define SCGC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("scgc check failed");

// next-cycle implication that also holds across reset
`define SCGC_ASSERT_RST(label, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("scgc reset check failed");

`endif

### hw/rtl/scgc_pkg.sv
// ----------------------------------------------------------------------------
// scgc_pkg
// shared constants and types of the serial crc generate/check unit
// ----------------------------------------------------------------------------
`default_nettype none

package scgc_pkg;

  localparam int DEFAULT_MAX_DEGREE  = 16;
  localparam int DEFAULT_QUEUE_DEPTH = 4;

  localparam int GEN_W      = 16;
  localparam int CFG_DEG_W  = 5;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_GENERATOR = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DEGREE    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MODE      = 2'd2;

  // register reset values
  localparam logic [GEN_W-1:0]     GEN_RESET    = 16'h10A1;
  localparam logic [CFG_DEG_W-1:0] DEGREE_RESET = 5'd16;
  localparam logic                 MODE_GENERATE = 1'b0;
  localparam logic                 MODE_CHECK    = 1'b1;

  typedef struct packed {
    logic                  valid;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
  } cfg_wr_t;

  typedef struct packed {
    logic out_bit;
    logic is_crc_bit;
    logic check_passed;
    logic end_of_run;
  } res_t;

endpackage

`default_nettype wire

### hw/rtl/scgc_queue.sv
// ----------------------------------------------------------------------------
// scgc_queue
// small register queue that decouples the front and back halves
// ----------------------------------------------------------------------------
`default_nettype none

module scgc_queue
  import scgc_pkg::*;
#(
  parameter int WIDTH = 8,
  parameter int DEPTH = DEFAULT_QUEUE_DEPTH
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] push_data,
  output logic                  full,
  input  wire logic             pop,
  output logic [WIDTH-1:0]      pop_data,
  output logic                  empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] entry_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(p + 1'b1);
  endfunction

  assign full     = (count_r == CNT_W'(DEPTH));
  assign empty    = (count_r == '0);
  assign pop_data = entry_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? ptr_inc(wr_ptr_r) : wr_ptr_r;
    rd_ptr_nxt = pop  ? ptr_inc(rd_ptr_r) : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = CNT_W'(count_r + 1'b1);
    end else if (pop && !push) begin
      count_nxt = CNT_W'(count_r - 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/scgc_front.sv
// ----------------------------------------------------------------------------
// scgc_front
// config registers, remainder update and job classification
// ----------------------------------------------------------------------------
`default_nettype none

module scgc_front
  import scgc_pkg::*;
#(
  parameter int MAX_DEGREE = DEFAULT_MAX_DEGREE,
  parameter int DEG_W      = $clog2(MAX_DEGREE + 1),
  parameter int JOB_W      = 4 + MAX_DEGREE + DEG_W
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire cfg_wr_t          cfg_wr,
  input  wire logic             in_push,
  input  wire logic             in_message_bit,
  input  wire logic             in_final_bit,
  input  wire logic             q_full,
  output logic                  q_push,
  output logic [JOB_W-1:0]      q_data
);

  typedef struct packed {
    logic                  ob;
    logic                  pass;
    logic                  eor;
    logic                  crc_run;
    logic [MAX_DEGREE-1:0] rem;
    logic [DEG_W-1:0]      deg;
  } job_t;

  logic [GEN_W-1:0]      gen_r;
  logic [CFG_DEG_W-1:0]  deg_r;
  logic                  mode_r;
  logic [MAX_DEGREE-1:0] rem_r, rem_nxt;

  logic [CFG_DEG_W:0]    deg_ext;
  logic [CFG_DEG_W:0]    deg_clip;
  logic [DEG_W-1:0]      eff_deg;
  logic [MAX_DEGREE-1:0] mask;
  logic [MAX_DEGREE-1:0] top_sel;
  logic [GEN_W+MAX_DEGREE-1:0] gen_wide;
  logic [MAX_DEGREE-1:0] gen_eff;
  logic [MAX_DEGREE-1:0] rem_cur;
  logic [MAX_DEGREE-1:0] rem_new;
  logic                  top;
  logic                  accept;
  job_t                  job;

  // clamp degree into 1..MAX_DEGREE
  always_comb begin
    deg_ext = {1'b0, deg_r};
    if (deg_ext == '0) begin
      deg_clip = (CFG_DEG_W + 1)'(1);
    end else if (deg_ext > (CFG_DEG_W + 1)'(MAX_DEGREE)) begin
      deg_clip = (CFG_DEG_W + 1)'(MAX_DEGREE);
    end else begin
      deg_clip = deg_ext;
    end
    eff_deg = DEG_W'(deg_clip);
  end

  always_comb begin
    for (int i = 0; i < MAX_DEGREE; i++) begin
      mask[i]    = (i < int'(eff_deg));
      top_sel[i] = (i == int'(eff_deg) - 1);
    end
  end

  assign gen_wide = {{MAX_DEGREE{1'b0}}, gen_r};
  assign gen_eff  = gen_wide[MAX_DEGREE-1:0] & mask;
  assign rem_cur  = rem_r & mask;
  assign top      = |(rem_cur & top_sel);

  // one long-division step
  always_comb begin
    if (mode_r == MODE_CHECK) begin
      rem_new = ((rem_cur << 1) | MAX_DEGREE'(in_message_bit)) & mask;
      if (top) begin
        rem_new = rem_new ^ gen_eff;
      end
    end else begin
      rem_new = (rem_cur << 1) & mask;
      if (top ^ in_message_bit) begin
        rem_new = rem_new ^ gen_eff;
      end
    end
  end

  assign accept  = in_push && !q_full;
  assign rem_nxt = in_final_bit ? '0 : rem_new;

  always_comb begin
    job.ob      = (mode_r == MODE_CHECK) ? 1'b0 : in_message_bit;
    job.pass    = (mode_r == MODE_CHECK) && (rem_new == '0);
    job.eor     = (mode_r == MODE_CHECK);
    job.crc_run = (mode_r == MODE_GENERATE) && in_final_bit;
    job.rem     = rem_new;
    job.deg     = eff_deg;
  end

  // check mode only reports on the final bit
  assign q_push = accept && ((mode_r == MODE_GENERATE) || in_final_bit);
  assign q_data = job;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gen_r  <= GEN_RESET;
      deg_r  <= DEGREE_RESET;
      mode_r <= MODE_GENERATE;
      rem_r  <= '0;
    end else begin
      if (cfg_wr.valid) begin
        unique case (cfg_wr.index)
          REG_GENERATOR: gen_r  <= cfg_wr.data[GEN_W-1:0];
          REG_DEGREE:    deg_r  <= cfg_wr.data[CFG_DEG_W-1:0];
          REG_MODE:      mode_r <= cfg_wr.data[0];
          default: ;
        endcase
      end
      if (accept) begin
        rem_r <= rem_nxt;
      end
    end
  end

endmodule

`default_nettype wire

### hw/rtl/scgc_back.sv
// ----------------------------------------------------------------------------
// scgc_back
// drains jobs, shifts out crc bits and holds the result register
// ----------------------------------------------------------------------------
`default_nettype none

module scgc_back
  import scgc_pkg::*;
#(
  parameter int MAX_DEGREE = DEFAULT_MAX_DEGREE,
  parameter int DEG_W      = $clog2(MAX_DEGREE + 1),
  parameter int JOB_W      = 4 + MAX_DEGREE + DEG_W
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             q_empty,
  input  wire logic [JOB_W-1:0] q_data,
  output logic                  q_pop,
  output logic                  out_valid,
  output res_t                  out_res,
  input  wire logic             out_pop
);

  typedef struct packed {
    logic                  ob;
    logic                  pass;
    logic                  eor;
    logic                  crc_run;
    logic [MAX_DEGREE-1:0] rem;
    logic [DEG_W-1:0]      deg;
  } job_t;

  job_t                  job;
  logic                  valid_r, valid_nxt;
  res_t                  res_r, res_nxt;
  logic [DEG_W-1:0]      cnt_r, cnt_nxt;
  logic [MAX_DEGREE-1:0] shift_r, shift_nxt;
  logic [DEG_W-1:0]      align_amt;
  logic                  load_ok;
  logic                  load;

  assign job       = q_data;
  assign align_amt = DEG_W'(MAX_DEGREE) - job.deg;
  assign load_ok   = !valid_r || out_pop;

  always_comb begin
    q_pop     = 1'b0;
    load      = 1'b0;
    res_nxt   = res_r;
    cnt_nxt   = cnt_r;
    shift_nxt = shift_r;
    if (load_ok) begin
      if (cnt_r != '0) begin
        // appended crc bits, msb first
        load                 = 1'b1;
        res_nxt.out_bit      = shift_r[MAX_DEGREE-1];
        res_nxt.is_crc_bit   = 1'b1;
        res_nxt.check_passed = 1'b0;
        res_nxt.end_of_run   = (cnt_r == DEG_W'(1));
        shift_nxt            = shift_r << 1;
        cnt_nxt              = DEG_W'(cnt_r - 1'b1);
      end else if (!q_empty) begin
        q_pop                = 1'b1;
        load                 = 1'b1;
        res_nxt.out_bit      = job.ob;
        res_nxt.is_crc_bit   = 1'b0;
        res_nxt.check_passed = job.pass;
        res_nxt.end_of_run   = job.eor;
        if (job.crc_run) begin
          cnt_nxt   = job.deg;
          shift_nxt = job.rem << align_amt;
        end
      end
    end
    valid_nxt = load ? 1'b1 : (out_pop ? 1'b0 : valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      cnt_r   <= '0;
    end else begin
      valid_r <= valid_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_r   <= res_nxt;
    shift_r <= shift_nxt;
  end

  assign out_valid = valid_r;
  assign out_res   = res_r;

endmodule

`default_nettype wire

### hw/rtl/serial_crc_generate_check_unit.sv
// ----------------------------------------------------------------------------
// serial_crc_generate_check_unit
// bit-serial crc generator and checker with programmable polynomial
// ----------------------------------------------------------------------------
// One message bit is taken per clock while the queue has room. The front half
// divides by the programmed generator (one shift and conditional xor per bit)
// and hands a short job to a small queue; the back half turns each job into
// results through a result register, so a bit can be accepted while an earlier
// result still waits to be popped. Sustained rate is one input bit per cycle
// while the queue has room. In generate mode every bit gives one echo result,
// and the final bit adds crc_degree appended crc bits, msb first, which the
// back half shifts out one per cycle as they are popped; the input keeps flowing
// until the queue fills (QUEUE_DEPTH jobs). In check mode only the final bit
// of a codeword gives a result, its pass flag set when the remainder is zero.
// The remainder clears after every final bit. Config writes are always ready
// and are meant for an idle unit. No clearing pass is needed after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module serial_crc_generate_check_unit
  import scgc_pkg::*;
#(
  parameter int MAX_DEGREE  = DEFAULT_MAX_DEGREE,
  parameter int QUEUE_DEPTH = DEFAULT_QUEUE_DEPTH
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  // config write channel
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  // input bit channel
  input  wire logic                  in_push,
  output logic                       in_full,
  input  wire logic                  in_message_bit,
  input  wire logic                  in_final_bit,
  // result channel
  output logic                       out_empty,
  input  wire logic                  out_pop,
  output logic                       out_out_bit,
  output logic                       out_is_crc_bit,
  output logic                       out_check_passed,
  output logic                       out_end_of_run
);

  localparam int DEG_W = $clog2(MAX_DEGREE + 1);
  localparam int JOB_W = 4 + MAX_DEGREE + DEG_W;

  cfg_wr_t          cfg_wr;
  logic             q_push;
  logic             q_pop;
  logic             q_full;
  logic             q_empty;
  logic [JOB_W-1:0] q_wdata;
  logic [JOB_W-1:0] q_rdata;
  logic             res_valid;
  res_t             res;

  // config registers take a request every cycle
  assign cfg_ready    = 1'b1;
  assign cfg_wr.valid = cfg_valid && cfg_ready;
  assign cfg_wr.index = cfg_index;
  assign cfg_wr.data  = cfg_data;

  // input stalls only when the job queue is full
  assign in_full = q_full;

  scgc_front #(
    .MAX_DEGREE (MAX_DEGREE),
    .DEG_W      (DEG_W),
    .JOB_W      (JOB_W)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_wr         (cfg_wr),
    .in_push        (in_push),
    .in_message_bit (in_message_bit),
    .in_final_bit   (in_final_bit),
    .q_full         (q_full),
    .q_push         (q_push),
    .q_data         (q_wdata)
  );

  scgc_queue #(
    .WIDTH (JOB_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_wdata),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_rdata),
    .empty     (q_empty)
  );

  scgc_back #(
    .MAX_DEGREE (MAX_DEGREE),
    .DEG_W      (DEG_W),
    .JOB_W      (JOB_W)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_data    (q_rdata),
    .q_pop     (q_pop),
    .out_valid (res_valid),
    .out_res   (res),
    .out_pop   (out_pop)
  );

  // result register drives the ports directly
  assign out_empty        = !res_valid;
  assign out_out_bit      = res.out_bit;
  assign out_is_crc_bit   = res.is_crc_bit;
  assign out_check_passed = res.check_passed;
  assign out_end_of_run   = res.end_of_run;

endmodule

`default_nettype wire

### hw/rtl/scgc_checker.sv
// ----------------------------------------------------------------------------
// scgc_checker
// port-level assertions for the serial crc unit, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

`include "serial_crc_generate_check_unit_assert.svh"

module scgc_checker (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic out_empty,
  input wire logic out_pop,
  input wire logic out_out_bit,
  input wire logic out_is_crc_bit,
  input wire logic out_check_passed,
  input wire logic out_end_of_run
);

  // nothing to pop right after reset
  `SCGC_ASSERT_RST(a_empty_after_reset, !rst_n, out_empty)

  // a stalled result holds
  `SCGC_ASSERT_NEXT(a_result_holds, !out_empty && !out_pop,
    !out_empty && $stable({out_out_bit, out_is_crc_bit, out_check_passed, out_end_of_run}))

  // pass flag only on a check result, never on a crc bit
  `SCGC_ASSERT_IMPL(a_pass_not_crc, !out_empty && out_check_passed, !out_is_crc_bit)

  // a pass flag always closes a run
  `SCGC_ASSERT_IMPL(a_pass_ends_run, !out_empty && out_check_passed, out_end_of_run)

endmodule

bind serial_crc_generate_check_unit scgc_checker u_scgc_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_empty        (out_empty),
  .out_pop          (out_pop),
  .out_out_bit      (out_out_bit),
  .out_is_crc_bit   (out_is_crc_bit),
  .out_check_passed (out_check_passed),
  .out_end_of_run   (out_end_of_run)
);

`default_nettype wire
